/* hw/rtl/vrsv_pkg.sv */
// Package for the vote record stream validator.
// Holds field widths, record phase codes, status codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package vrsv_pkg;

   localparam int BYTE_W    = 8;
   localparam int TOTAL_W   = 16;
   localparam int PHASE_W   = 3;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;
   localparam int RSP_DAT_W = 16;

   // record phases; codes above PH_DONE behave as a finished record
   localparam logic [PHASE_W-1:0] PH_COUNT   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_NAMELEN = 3'd1;
   localparam logic [PHASE_W-1:0] PH_NAME    = 3'd2;
   localparam logic [PHASE_W-1:0] PH_PLO     = 3'd3;
   localparam logic [PHASE_W-1:0] PH_PHI     = 3'd4;
   localparam logic [PHASE_W-1:0] PH_DONE    = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_LEN     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_CONTENT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_VOTES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_NAME  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_NAME  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_REQ_TOTAL = 2'd3;

   localparam logic [BYTE_W-1:0]  RST_MAX_VOTES = 8'd53;
   localparam logic [BYTE_W-1:0]  RST_MIN_NAME  = 8'd1;
   localparam logic [BYTE_W-1:0]  RST_MAX_NAME  = 8'd20;
   localparam logic [TOTAL_W-1:0] RST_REQ_TOTAL = 16'd10000;

   localparam logic [TOTAL_W-1:0] PERCENT_MIN = 16'd1;
   localparam logic [TOTAL_W-1:0] PERCENT_MAX = 16'd10000;

   localparam logic [BYTE_W-1:0] CHAR_LOW  = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_HIGH = 8'h7E;

endpackage

/* hw/rtl/vote_record_stream_validator.sv */
// Vote record stream validator: one byte per beat, one status beat per frame.
// Depends on vrsv_pkg for widths, phase codes and status codes.
`timescale 1ns / 1ps

// Takes one record byte per beat on req_ (tlast marks the frame's last byte)
// and returns one status beat on rsp_ the cycle after the last byte is taken.
// A byte is accepted every cycle; the record state advances in a single pass
// of compares and one 16-bit add, and the status sits in an output register
// that is refilled in the same cycle it is taken, so req_tready drops only
// while a status beat waits unread. rsp_tdata carries status in bits [1:0]
// (0 ok, 1 wrong length, 2 content error) and the frame's count byte in
// bits [9:2]. Write limits through csr_ only while no frame is open; the block does not enforce it.
module vote_record_stream_validator (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_we,
   input  logic [vrsv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vrsv_pkg::CSR_DAT_W-1:0]  csr_wdata,
   // record bytes
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [vrsv_pkg::BYTE_W-1:0]     req_tdata,   // [7:0] data_byte
   input  logic                            req_tlast,   // frame_end
   // status
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [vrsv_pkg::RSP_DAT_W-1:0]  rsp_tdata    // [1:0] status, [9:2] vote_count
);
   import vrsv_pkg::*;

   logic [BYTE_W-1:0]   max_votes_ff, min_name_ff, max_name_ff;
   logic [TOTAL_W-1:0]  req_total_ff;

   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [BYTE_W-1:0]   votes_left_ff, votes_left_in;
   logic [BYTE_W-1:0]   name_left_ff, name_left_in;
   logic                bad_char_ff, bad_char_in;
   logic [BYTE_W-1:0]   pct_low_ff, pct_low_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [STATUS_W-1:0] first_err_ff, first_err_in;
   logic [BYTE_W-1:0]   count_ff, count_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [BYTE_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                beat;
   logic                last_beat;
   logic [BYTE_W-1:0]   b;
   logic [TOTAL_W-1:0]  pct;
   logic [TOTAL_W-1:0]  sum;
   logic [BYTE_W-1:0]   name_dec;
   logic [BYTE_W-1:0]   votes_dec;
   logic                bad_now;
   logic [STATUS_W-1:0] frame_status;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign beat       = req_tvalid && req_tready;
   assign last_beat  = beat && req_tlast;
   assign b          = req_tdata;

   assign pct       = {b, pct_low_ff};
   assign sum       = total_ff + pct;
   assign name_dec  = name_left_ff - 8'd1;
   assign votes_dec = votes_left_ff - 8'd1;
   assign bad_now   = bad_char_ff || (b < CHAR_LOW) || (b > CHAR_HIGH);

   always_comb begin
      phase_in      = phase_ff;
      votes_left_in = votes_left_ff;
      name_left_in  = name_left_ff;
      bad_char_in   = bad_char_ff;
      pct_low_in    = pct_low_ff;
      total_in      = total_ff;
      first_err_in  = first_err_ff;
      count_in      = count_ff;

      // after an error, drop bytes until the frame ends
      if (first_err_ff == ST_OK) begin
         unique case (phase_ff)
            PH_COUNT: begin
               count_in = b;
               if (b > max_votes_ff) begin
                  first_err_in = ST_CONTENT;
               end else if (b == '0) begin
                  phase_in = PH_DONE;
               end else begin
                  votes_left_in = b;
                  phase_in      = PH_NAMELEN;
               end
            end
            PH_NAMELEN: begin
               if (b < min_name_ff || b > max_name_ff) begin
                  first_err_in = ST_CONTENT;
               end else begin
                  name_left_in = b;
                  bad_char_in  = 1'b0;
                  phase_in     = (b == '0) ? PH_PLO : PH_NAME;
               end
            end
            PH_NAME: begin
               bad_char_in  = bad_now;
               name_left_in = name_dec;
               if (name_dec == '0) begin
                  if (bad_now) begin
                     first_err_in = ST_CONTENT;
                  end else begin
                     phase_in = PH_PLO;
                  end
               end
            end
            PH_PLO: begin
               pct_low_in = b;
               phase_in   = PH_PHI;
            end
            PH_PHI: begin
               if (pct < PERCENT_MIN || pct > PERCENT_MAX) begin
                  first_err_in = ST_CONTENT;
               end else begin
                  total_in      = sum;
                  votes_left_in = votes_dec;
                  if (votes_dec == '0) begin
                     // count is nonzero here, so the total check applies
                     if (sum != req_total_ff) begin
                        first_err_in = ST_CONTENT;
                     end
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = PH_NAMELEN;
                  end
               end
            end
            default: begin
               first_err_in = ST_LEN;
            end
         endcase
      end

      priority if (first_err_in != ST_OK) begin
         frame_status = first_err_in;
      end else if (phase_in < PH_DONE) begin
         frame_status = ST_LEN;
      end else begin
         frame_status = ST_OK;
      end

      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if (last_beat) begin
         rsp_status_in = frame_status;
         rsp_count_in  = count_in;
      end
      priority if (last_beat) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_votes_ff <= RST_MAX_VOTES;
         min_name_ff  <= RST_MIN_NAME;
         max_name_ff  <= RST_MAX_NAME;
         req_total_ff <= RST_REQ_TOTAL;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MAX_VOTES: max_votes_ff <= csr_wdata[BYTE_W-1:0];
            REG_MIN_NAME:  min_name_ff  <= csr_wdata[BYTE_W-1:0];
            REG_MAX_NAME:  max_name_ff  <= csr_wdata[BYTE_W-1:0];
            REG_REQ_TOTAL: req_total_ff <= csr_wdata[TOTAL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || last_beat) begin
         phase_ff      <= PH_COUNT;
         votes_left_ff <= '0;
         name_left_ff  <= '0;
         bad_char_ff   <= 1'b0;
         pct_low_ff    <= '0;
         total_ff      <= '0;
         first_err_ff  <= ST_OK;
         count_ff      <= '0;
      end else if (beat) begin
         phase_ff      <= phase_in;
         votes_left_ff <= votes_left_in;
         name_left_ff  <= name_left_in;
         bad_char_ff   <= bad_char_in;
         pct_low_ff    <= pct_low_in;
         total_ff      <= total_in;
         first_err_ff  <= first_err_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DAT_W - STATUS_W - BYTE_W){1'b0}}, rsp_count_ff, rsp_status_ff};

`ifndef SYNTH
   a_last_gives_status: assert property (@(posedge clock) disable iff (reset)
      last_beat |=> rsp_valid_ff)
      else $error("status beat missing after frame end");

   a_frame_cleared: assert property (@(posedge clock) disable iff (reset)
      last_beat |=> (phase_ff == PH_COUNT) && (first_err_ff == ST_OK) && (total_ff == '0))
      else $error("frame state not cleared after frame end");

   a_no_spurious_status: assert property (@(posedge clock) disable iff (reset)
      (beat && !req_tlast && (!rsp_valid_ff || rsp_tready)) |=> !rsp_valid_ff)
      else $error("status beat raised without frame end");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff == ST_OK || rsp_status_ff == ST_LEN
                        || rsp_status_ff == ST_CONTENT))
      else $error("undefined status code");

   a_error_freezes: assert property (@(posedge clock) disable iff (reset)
      (beat && !req_tlast && first_err_ff != ST_OK) |=> $stable(phase_ff) && $stable(total_ff))
      else $error("record state moved after an error");
`endif

endmodule

/* tb/sv/tb_top.sv */
// Testbench for vote_record_stream_validator: streams vote record frames,
// predicts each frame's status beat and checks every returned beat.
// Depends on vrsv_pkg and the validator RTL.
`timescale 1ns / 1ps

module tb_top;
   import vrsv_pkg::*;

   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 4000;
   localparam int PRINT_LIMIT = 100;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   vote_count;
   } frame_status_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [BYTE_W-1:0]    req_tdata = '0;
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_DAT_W-1:0] rsp_tdata;

   vote_record_stream_validator u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] data_byte
      .req_tlast  (req_tlast),   // frame_end
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // [1:0] status, [9:2] vote_count
   );

   always #5 clock = ~clock;

   // limits as the block holds them
   logic [BYTE_W-1:0]   cfg_max_votes;
   logic [BYTE_W-1:0]   cfg_min_name;
   logic [BYTE_W-1:0]   cfg_max_name;
   logic [TOTAL_W-1:0]  cfg_req_total;

   // record parser state of the predictor
   logic [PHASE_W-1:0]  rec_phase;
   logic [BYTE_W-1:0]   rec_votes_left;
   logic [BYTE_W-1:0]   rec_name_left;
   logic                rec_bad_char;
   logic [BYTE_W-1:0]   rec_pct_low;
   logic [TOTAL_W-1:0]  rec_total;
   logic [STATUS_W-1:0] rec_err;
   logic [BYTE_W-1:0]   rec_count;

   frame_status_type    pending_status[$];
   frame_status_type    oldest_status;
   logic [BYTE_W-1:0]   frame[$];
   int                  name_pos[$];
   int                  pct_pos[$];

   int err_count = 0;
   int sent_bytes = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   function automatic void clear_record();
      rec_phase      = PH_COUNT;
      rec_votes_left = '0;
      rec_name_left  = '0;
      rec_bad_char   = 1'b0;
      rec_pct_low    = '0;
      rec_total      = '0;
      rec_err        = ST_OK;
      rec_count      = '0;
   endfunction

   function automatic void close_votes();
      if (rec_count != 0 && rec_total != cfg_req_total) rec_err = ST_CONTENT;
      rec_phase = PH_DONE;
   endfunction

   // advance the record parser by one byte; queue a status on the frame end
   function automatic void parse_vote_byte(logic [BYTE_W-1:0] b, logic last);
      logic [TOTAL_W-1:0]  pct;
      logic [STATUS_W-1:0] st;
      if (rec_err == ST_OK) begin
         case (rec_phase)
            PH_COUNT: begin
               rec_count = b;
               if (b > cfg_max_votes) rec_err = ST_CONTENT;
               else if (b == 0) close_votes();
               else begin
                  rec_votes_left = b;
                  rec_phase = PH_NAMELEN;
               end
            end
            PH_NAMELEN: begin
               if (b < cfg_min_name || b > cfg_max_name) rec_err = ST_CONTENT;
               else begin
                  rec_name_left = b;
                  rec_bad_char = 1'b0;
                  rec_phase = (b == 0) ? PH_PLO : PH_NAME;
               end
            end
            PH_NAME: begin
               if (b < CHAR_LOW || b > CHAR_HIGH) rec_bad_char = 1'b1;
               rec_name_left = rec_name_left - 1'b1;
               if (rec_name_left == 0) begin
                  if (rec_bad_char) rec_err = ST_CONTENT;
                  else rec_phase = PH_PLO;
               end
            end
            PH_PLO: begin
               rec_pct_low = b;
               rec_phase = PH_PHI;
            end
            PH_PHI: begin
               pct = {b, rec_pct_low};
               if (pct < PERCENT_MIN || pct > PERCENT_MAX) rec_err = ST_CONTENT;
               else begin
                  rec_total = rec_total + pct;
                  rec_votes_left = rec_votes_left - 1'b1;
                  if (rec_votes_left == 0) close_votes();
                  else rec_phase = PH_NAMELEN;
               end
            end
            default: rec_err = ST_LEN;
         endcase
      end
      if (last) begin
         if (rec_err != ST_OK) st = rec_err;
         else if (rec_phase < PH_DONE) st = ST_LEN;
         else st = ST_OK;
         pending_status.push_back('{status: st, vote_count: rec_count});
         clear_record();
      end
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      err_count++;
      if (err_count <= PRINT_LIMIT)
         $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   // check every status beat against the oldest pending frame
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_status.size() == 0) begin
            report_mismatch("status beat with no frame pending", int'(rsp_tdata), 0);
         end else begin
            oldest_status = pending_status.pop_front();
            if (rsp_tdata[1:0] != oldest_status.status)
               report_mismatch("status", int'(rsp_tdata[1:0]),
                               int'(oldest_status.status));
            if (rsp_tdata[9:2] != oldest_status.vote_count)
               report_mismatch("vote_count", int'(rsp_tdata[9:2]),
                               int'(oldest_status.vote_count));
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_byte(logic [BYTE_W-1:0] b, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sent_bytes++;
      parse_vote_byte(b, last);
   endtask

   task automatic send_frame();
      foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
   endtask

   // stop offering bytes until every status is back, then let the block settle
   task automatic drain_frames();
      req_tvalid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_limits(logic [7:0] max_votes, logic [7:0] min_name,
                              logic [7:0] max_name, logic [15:0] req_total);
      csr_we <= 1'b1;
      csr_index <= REG_MAX_VOTES;
      csr_wdata <= {8'd0, max_votes};
      @(posedge clock);
      csr_index <= REG_MIN_NAME;
      csr_wdata <= {8'd0, min_name};
      @(posedge clock);
      csr_index <= REG_MAX_NAME;
      csr_wdata <= {8'd0, max_name};
      @(posedge clock);
      csr_index <= REG_REQ_TOTAL;
      csr_wdata <= req_total;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_max_votes = max_votes;
      cfg_min_name  = min_name;
      cfg_max_name  = max_name;
      cfg_req_total = req_total;
   endtask

   function automatic int pick_name_len();
      int top;
      if (cfg_min_name > cfg_max_name) return $urandom_range(8);
      if ($urandom_range(9) == 0) return $urandom_range(cfg_max_name, cfg_min_name);
      top = (cfg_max_name > cfg_min_name + 6) ? cfg_min_name + 6 : cfg_max_name;
      return $urandom_range(top, cfg_min_name);
   endfunction

   // build a record that passes every check when the limits allow it
   function automatic void build_record(int max_n);
      int n, len, t, lo, hi, v;
      frame.delete();
      name_pos.delete();
      pct_pos.delete();
      n = $urandom_range((cfg_max_votes < max_n) ? cfg_max_votes : max_n);
      frame.push_back(n[7:0]);
      t = int'(cfg_req_total);
      if (n > 0) while (t < n) t += 65536;
      for (int i = 0; i < n; i++) begin
         len = pick_name_len();
         frame.push_back(len[7:0]);
         repeat (len) begin
            name_pos.push_back(frame.size());
            frame.push_back(8'($urandom_range(CHAR_HIGH, CHAR_LOW)));
         end
         lo = t - 10000 * (n - 1 - i);
         if (lo < 1) lo = 1;
         hi = t - (n - 1 - i);
         if (hi > 10000) hi = 10000;
         v = (lo > hi) ? $urandom_range(10000, 1) : $urandom_range(hi, lo);
         t -= v;
         pct_pos.push_back(frame.size());
         frame.push_back(v[7:0]);
         frame.push_back(v[15:8]);
      end
   endfunction

   // break the record in one of several ways
   function automatic void mangle_record();
      int p, v, keep;
      case ($urandom_range(5))
         0: begin
            if (frame.size() > 1) begin
               keep = $urandom_range(frame.size() - 1, 1);
               while (frame.size() > keep) void'(frame.pop_back());
            end
         end
         1: repeat ($urandom_range(3, 1)) frame.push_back(8'($urandom_range(255)));
         2: frame[$urandom_range(frame.size() - 1)] = 8'($urandom_range(255));
         3: begin
            frame.delete();
            repeat ($urandom_range(12, 1)) frame.push_back(8'($urandom_range(255)));
         end
         4: begin
            if (name_pos.size() != 0) begin
               p = name_pos[$urandom_range(name_pos.size() - 1)];
               frame[p] = 8'($urandom_range(1) ? $urandom_range(31)
                                               : $urandom_range(255, 127));
            end
         end
         default: begin
            if (pct_pos.size() != 0) begin
               p = pct_pos[$urandom_range(pct_pos.size() - 1)];
               v = $urandom_range(1) ? 0 : $urandom_range(65535, 10001);
               frame[p] = v[7:0];
               frame[p + 1] = v[15:8];
            end
         end
      endcase
   endfunction

   task automatic run_frames(int byte_budget, int max_n);
      int start;
      start = sent_bytes;
      while (sent_bytes - start < byte_budget) begin
         build_record(max_n);
         if ($urandom_range(99) < 25) mangle_record();
         send_frame();
      end
   endtask

   task automatic test_directed_frames();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      frame = {8'h00};                                 // zero count
      send_frame();
      frame = {8'hFF};                                 // count over limit
      send_frame();
      frame = {8'h01};                                 // ends after count
      send_frame();
      frame = {8'h01, 8'h02, 8'h20, 8'h7E, 8'h10, 8'h27};
      send_frame();
      frame = {8'h01, 8'h01, 8'h7F};                   // bad char ends the name
      send_frame();
      frame = {8'h01, 8'h03, 8'h1F};                   // cut inside a bad name
      send_frame();
      frame = {8'h01, 8'h01, 8'h41, 8'h11, 8'h27};     // percent 10001
      send_frame();
      frame = {8'h00, 8'h80};                          // extra byte after record
      send_frame();
      drain_frames();
   endtask

   task automatic test_random_traffic();
      int idle_mix[4][2] = '{'{0, 0}, '{78, 0}, '{0, 78}, '{32, 32}};
      for (int k = 0; k < 4; k++) begin
         send_idle_pct = idle_mix[k][0];
         rsp_stall_pct = idle_mix[k][1];
         run_frames(100, 4);
         drain_frames();
      end
   endtask

   task automatic test_register_settings();
      int lo;
      send_idle_pct = 32;
      rsp_stall_pct = 32;
      load_limits(8'd0, 8'd0, 8'd0, 16'd0);
      run_frames(40, 4);
      drain_frames();
      load_limits(8'd255, 8'd0, 8'd255, 16'd65535);
      run_frames(150, 8);
      drain_frames();
      load_limits(8'd3, 8'd255, 8'd255, 16'd10000);
      run_frames(250, 1);
      drain_frames();
      // zero-length names only
      load_limits(8'd255, 8'd0, 8'd0, 16'd0);
      run_frames(150, 8);
      drain_frames();
      // min above max: no name length passes
      load_limits(8'd5, 8'd4, 8'd2, 16'd3000);
      run_frames(60, 4);
      drain_frames();
      repeat (2) begin
         lo = $urandom_range(6);
         load_limits(8'($urandom_range(255)), 8'(lo), 8'(lo + $urandom_range(10)),
                     16'($urandom_range(65535)));
         run_frames(80, 6);
         drain_frames();
      end
   endtask

   task automatic test_back_pressure();
      load_limits(RST_MAX_VOTES, RST_MIN_NAME, RST_MAX_NAME, RST_REQ_TOTAL);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      // hold the status side long enough for the input to back up
      hold_requests = hold_requests + 1;
      run_frames(150, 3);
      drain_frames();
      run_frames(40, 3);
      drain_frames();
   endtask

   initial begin
      cfg_max_votes = RST_MAX_VOTES;
      cfg_min_name  = RST_MIN_NAME;
      cfg_max_name  = RST_MAX_NAME;
      cfg_req_total = RST_REQ_TOTAL;
      clear_record();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_frames();
      test_random_traffic();
      test_register_settings();
      test_back_pressure();
      drain_frames();
      repeat (8) @(posedge clock);
      if (err_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
